FILE: hdl/css_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_pkg
// Types and constants shared by the cursor sequence store cells, control,
// top level and checker.
// ----------------------------------------------------------------------------
package css_pkg;

   localparam int DATA_W     = 32;
   localparam int OPCODE_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int STATUS_W   = 2;
   localparam int CELL_IDX_W = 11;

   typedef enum logic [OPCODE_W-1:0] {
      OP_START   = 3'd0,
      OP_END     = 3'd1,
      OP_ADVANCE = 3'd2,
      OP_INSERT  = 3'd3,
      OP_ATTACH  = 3'd4,
      OP_REMOVE  = 3'd5,
      OP_QUERY   = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NO_ITEM = 2'd2
   } status_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [DATA_W-1:0]   entry_value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   current_value;
      logic                has_item;
      logic [COUNT_W-1:0]  item_count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic                  shift_up;
      logic                  shift_down;
      logic [CELL_IDX_W-1:0] pos;
      logic [CELL_IDX_W-1:0] new_cursor;
      logic [DATA_W-1:0]     word;
   } cell_cmd_type;

   typedef struct packed {
      logic                valid;
      logic                has_item;
      logic [COUNT_W-1:0]  item_count;
      logic [STATUS_W-1:0] status;
   } stage_type;

endpackage

FILE: hdl/css_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_cell
// One storage place of the sequence: holds a word and a cursor mark, takes
// its left neighbor on insert and its right neighbor on remove.
// ----------------------------------------------------------------------------
module css_cell #(
   parameter int INDEX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  css_pkg::cell_cmd_type       cmd,
   input  logic [css_pkg::DATA_W-1:0]  left_value,
   input  logic [css_pkg::DATA_W-1:0]  right_value,
   output logic [css_pkg::DATA_W-1:0]  value,
   output logic [css_pkg::DATA_W-1:0]  marked_value
);
   import css_pkg::*;

   localparam logic [CELL_IDX_W-1:0] MY_POS  = CELL_IDX_W'(INDEX);
   localparam logic [CELL_IDX_W-1:0] MY_MARK = CELL_IDX_W'(INDEX + 1);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              mark_ff;
   logic              mark_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.shift_up) begin
         if (MY_POS > cmd.pos) begin
            value_in = left_value;
         end else if (MY_POS == cmd.pos) begin
            value_in = cmd.word;
         end
      end else if (cmd.shift_down) begin
         if (MY_POS >= cmd.pos) begin
            value_in = right_value;
         end
      end
      mark_in = (cmd.new_cursor == MY_MARK);
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   assign value        = value_ff;
   assign marked_value = value_ff & {DATA_W{mark_ff}};

endmodule

FILE: hdl/css_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_ctrl
// Cursor and count bookkeeping: decodes each item into a shift command for
// the cell row and registers the status for the result.
// ----------------------------------------------------------------------------
module css_ctrl #(
   parameter int CAPACITY = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  css_pkg::req_type        req_item,
   output css_pkg::cell_cmd_type   cmd,
   output css_pkg::stage_type      stage
);
   import css_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] cursor_ff;
   logic [CNT_W-1:0] cursor_in;
   logic [CNT_W-1:0] pos;
   logic             shift_up;
   logic             shift_down;
   status_type       status;
   stage_type        stage_ff;
   stage_type        stage_in;

   always_comb begin
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      pos        = '0;
      shift_up   = 1'b0;
      shift_down = 1'b0;
      status     = ST_OK;
      if (accept) begin
         case (opcode_type'(req_item.opcode))
            OP_START: begin
               cursor_in = (count_ff != '0) ? ONE : '0;
            end
            OP_END: begin
               cursor_in = count_ff;
            end
            OP_ADVANCE: begin
               if (cursor_ff != '0) begin
                  cursor_in = (cursor_ff < count_ff) ? cursor_ff + ONE : '0;
               end
            end
            OP_INSERT, OP_ATTACH: begin
               if (count_ff >= CAP_CNT) begin
                  status = ST_FULL;
               end else begin
                  if (opcode_type'(req_item.opcode) == OP_INSERT) begin
                     pos = (cursor_ff != '0) ? cursor_ff - ONE : '0;
                  end else begin
                     pos = (cursor_ff != '0) ? cursor_ff : count_ff;
                  end
                  shift_up  = 1'b1;
                  count_in  = count_ff + ONE;
                  cursor_in = pos + ONE;
               end
            end
            OP_REMOVE: begin
               if (cursor_ff == '0 || cursor_ff > count_ff) begin
                  status = ST_NO_ITEM;
               end else begin
                  pos        = cursor_ff - ONE;
                  shift_down = 1'b1;
                  count_in   = count_ff - ONE;
                  if (cursor_ff > count_ff - ONE) begin
                     cursor_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cmd.shift_up   = shift_up;
      cmd.shift_down = shift_down;
      cmd.pos        = CELL_IDX_W'(pos);
      cmd.new_cursor = CELL_IDX_W'(cursor_in);
      cmd.word       = req_item.entry_value;

      stage_in.valid      = accept;
      stage_in.has_item   = (cursor_in != '0);
      stage_in.item_count = COUNT_W'(count_in);
      stage_in.status     = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         cursor_ff      <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         count_ff       <= count_in;
         cursor_ff      <= cursor_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.has_item   <= stage_in.has_item;
      stage_ff.item_count <= stage_in.item_count;
      stage_ff.status     <= stage_in.status;
   end

   assign stage = stage_ff;

endmodule

FILE: hdl/cursor_sequence_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_sequence_store_unit
// Ordered word store with a cursor, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item and raise start; the item is taken at a rising edge with
//   start high and busy low. busy is always low, so one item per cycle.
//   Each item yields exactly one result on rsp_item, marked by rsp_valid for
//   one cycle: the cell row, cursor and status stage update at the accepting
//   edge, and the marked cell is then picked out into the result register.
//   Insert shifts the later cells up and remove shifts them down, every
//   cell moving in parallel, so the shift never costs extra cycles.
//   Results arrive in item order and cannot be held off; a receiver must
//   take each one in its strobe cycle.
//   Synchronous reset empties the store and puts the cursor off the end;
//   stale cell contents are never shown, as only places below the count are
//   reachable by the cursor.
// ----------------------------------------------------------------------------
module cursor_sequence_store_unit #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  css_pkg::req_type req_item,
   output logic             rsp_valid,
   output css_pkg::rsp_type rsp_item
);
   import css_pkg::*;

   logic              accept;
   cell_cmd_type      cmd;
   stage_type         stage;
   logic [DATA_W-1:0] cell_value  [CAPACITY];
   logic [DATA_W-1:0] cell_marked [CAPACITY];
   logic [DATA_W-1:0] current_value;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   css_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .cmd      (cmd),
      .stage    (stage)
   );

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [DATA_W-1:0] left_value;
      logic [DATA_W-1:0] right_value;

      if (k == 0) begin : g_first
         assign left_value = req_item.entry_value;
      end else begin : g_mid_left
         assign left_value = cell_value[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[k];
      end else begin : g_mid_right
         assign right_value = cell_value[k+1];
      end

      css_cell #(
         .INDEX (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .left_value   (left_value),
         .right_value  (right_value),
         .value        (cell_value[k]),
         .marked_value (cell_marked[k])
      );
   end

   always_comb begin
      current_value = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         current_value = current_value | cell_marked[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage.valid;
      end
      rsp_ff.current_value <= current_value;
      rsp_ff.has_item      <= stage.has_item;
      rsp_ff.item_count    <= stage.item_count;
      rsp_ff.status        <= stage.status;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: hdl/css_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks for the cursor sequence store: result timing and
// consistency of the result fields.
// ----------------------------------------------------------------------------
module css_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input css_pkg::req_type req_item,
   input logic             rsp_valid,
   input css_pkg::rsp_type rsp_item
);
   import css_pkg::*;

   logic [DATA_W-1:0] req_word;

   assign req_word = req_item.entry_value;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("accepted item gave no result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted item");

   a_empty_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.has_item |-> rsp_item.current_value == '0)
      else $error("nonzero value with no current item");

   a_remove_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ST_NO_ITEM |-> !rsp_item.has_item)
      else $error("failed remove reports a current item");

   a_insert_lands: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ST_OK
      && $past(req_item.opcode == OP_INSERT || req_item.opcode == OP_ATTACH, 2)
      && $past(start && !busy, 2)
      |-> rsp_item.has_item && rsp_item.current_value == $past(req_word, 2))
      else $error("inserted word is not under the cursor");

endmodule

bind cursor_sequence_store_unit css_checker u_css_checker (.*);

FILE: sim/tb_cursor_sequence_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cursor_sequence_store_unit
// Drives the cursor sequence store with a short table of directed items and
// then with phases of random items that grow, shrink or churn the store, so
// that it runs full and empty many times. A behavioral copy of the store in
// the bench predicts every result not fixed by a table row; results are
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_cursor_sequence_store_unit;
   import css_pkg::*;

   localparam int               CAPACITY   = 64;
   localparam int               RAND_ITEMS = 1500;
   localparam int               CALM_ITEMS = 200;
   localparam int               CYCLE_CAP  = 200000;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
   localparam logic [DATA_W-1:0]   ALL_ONES  = '1;

   typedef enum int {GROW, SHRINK, CHURN} phase_type;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [DATA_W-1:0]   val;
      bit                  fixed;
      rsp_type             want;
   } drill_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   bit      tag_fixed;
   rsp_type tag_want;

   logic [DATA_W-1:0] seq_words [CAPACITY];
   int                seq_count;
   int                seq_cursor;

   rsp_type       pending_q [$];
   drill_row_type drill_q [$];
   int            fail_count;
   int            cycle_count;

   cursor_sequence_store_unit #(.CAPACITY(CAPACITY)) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic rsp_type step_store(req_type r);
      rsp_type    res;
      status_type st;
      int         k;
      int         pos;
      st  = ST_OK;
      pos = -1;
      case (r.opcode)
         OP_START: seq_cursor = (seq_count != 0) ? 1 : 0;
         OP_END: seq_cursor = seq_count;
         OP_ADVANCE: begin
            if (seq_cursor != 0)
               seq_cursor = (seq_cursor < seq_count) ? seq_cursor + 1 : 0;
         end
         OP_INSERT: begin
            if (seq_count >= CAPACITY) st = ST_FULL;
            else pos = (seq_cursor != 0) ? seq_cursor - 1 : 0;
         end
         OP_ATTACH: begin
            if (seq_count >= CAPACITY) st = ST_FULL;
            else pos = (seq_cursor != 0) ? seq_cursor : seq_count;
         end
         OP_REMOVE: begin
            if (seq_cursor == 0 || seq_cursor > seq_count) begin
               st = ST_NO_ITEM;
            end else begin
               for (k = seq_cursor - 1; k + 1 < seq_count; k++)
                  seq_words[k] = seq_words[k + 1];
               seq_count--;
               if (seq_cursor > seq_count) seq_cursor = 0;
            end
         end
         default: ;
      endcase
      if (pos >= 0) begin
         for (k = seq_count; k > pos; k--)
            seq_words[k] = seq_words[k - 1];
         seq_words[pos] = r.entry_value;
         seq_count++;
         seq_cursor = pos + 1;
      end
      res.current_value = (seq_cursor != 0) ? seq_words[seq_cursor - 1] : '0;
      res.has_item      = (seq_cursor != 0);
      res.item_count    = COUNT_W'(seq_count);
      res.status        = st;
      return res;
   endfunction

   function automatic drill_row_type row(logic [OPCODE_W-1:0] op, logic [DATA_W-1:0] val,
                                         bit fixed, rsp_type want);
      drill_row_type d;
      d.op    = op;
      d.val   = val;
      d.fixed = fixed;
      d.want  = want;
      return d;
   endfunction

   function automatic rsp_type rsp(logic [DATA_W-1:0] v, logic h, int n, status_type s);
      rsp_type r;
      r.current_value = v;
      r.has_item      = h;
      r.item_count    = COUNT_W'(n);
      r.status        = s;
      return r;
   endfunction

   task automatic note_failure(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display({"%0t %s: expected val=%h item=%b count=%0d status=%0d,",
                   " got val=%h item=%b count=%0d status=%0d"},
                  $realtime, what, want.current_value, want.has_item, want.item_count,
                  want.status, got.current_value, got.has_item, got.item_count, got.status);
   endtask

   task automatic drive_item(logic [OPCODE_W-1:0] op, logic [DATA_W-1:0] val,
                             bit fixed, rsp_type want);
      start     <= 1'b1;
      req_item  <= '{op, val};
      tag_fixed <= fixed;
      tag_want  <= want;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst(bit allowed);
      if (allowed && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            want = step_store(req_item);
            if (tag_fixed) want = tag_want;
            pending_q.push_back(want);
         end
         if (rsp_valid) begin
            if (pending_q.size() == 0) begin
               note_failure("unexpected result", '0, rsp_item);
            end else begin
               want = pending_q.pop_front();
               if (rsp_item.current_value !== want.current_value ||
                   rsp_item.has_item !== want.has_item ||
                   rsp_item.item_count !== want.item_count ||
                   rsp_item.status !== want.status)
                  note_failure("result mismatch", want, rsp_item);
            end
         end
      end
   end

   initial begin : stim
      drill_row_type       d;
      phase_type           mode;
      logic [OPCODE_W-1:0] op;
      logic [DATA_W-1:0]   val;
      int                 n;
      int                 roll;
      int                 p_ins;
      int                 p_att;
      int                 p_rem;
      rsp_type            zero;

      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      tag_fixed   = 1'b0;
      tag_want    = '0;
      fail_count  = 0;
      cycle_count = 0;
      seq_count   = 0;
      seq_cursor  = 0;
      zero        = rsp('0, 1'b0, 0, ST_OK);

      drill_q.push_back(row(OP_QUERY,   32'h0,        1, zero));
      drill_q.push_back(row(OP_START,   32'h0,        1, zero));
      drill_q.push_back(row(OP_END,     32'h0,        1, zero));
      drill_q.push_back(row(OP_ADVANCE, 32'h0,        1, zero));
      drill_q.push_back(row(OP_REMOVE,  32'h0,        1, rsp('0, 1'b0, 0, ST_NO_ITEM)));
      drill_q.push_back(row(OP_UNUSED,  32'h5A5A5A5A, 1, zero));
      drill_q.push_back(row(OP_INSERT,  ALL_ONES,     1, rsp(ALL_ONES, 1'b1, 1, ST_OK)));
      drill_q.push_back(row(OP_ADVANCE, 32'h0,        1, rsp('0, 1'b0, 1, ST_OK)));
      drill_q.push_back(row(OP_INSERT,  32'h0,        1, rsp('0, 1'b1, 2, ST_OK)));
      drill_q.push_back(row(OP_ADVANCE, 32'h0,        1, rsp(ALL_ONES, 1'b1, 2, ST_OK)));
      drill_q.push_back(row(OP_ADVANCE, 32'h0,        1, rsp('0, 1'b0, 2, ST_OK)));
      drill_q.push_back(row(OP_ATTACH,  32'h12345678, 1, rsp(32'h12345678, 1'b1, 3, ST_OK)));
      drill_q.push_back(row(OP_START,   32'h0,        1, rsp('0, 1'b1, 3, ST_OK)));
      drill_q.push_back(row(OP_ATTACH,  32'h80000001, 0, zero));
      drill_q.push_back(row(OP_END,     32'h0,        0, zero));
      drill_q.push_back(row(OP_ATTACH,  32'h7FFFFFFE, 0, zero));
      drill_q.push_back(row(OP_INSERT,  32'h00000001, 0, zero));
      drill_q.push_back(row(OP_REMOVE,  32'h0,        0, zero));
      drill_q.push_back(row(OP_END,     32'h0,        0, zero));
      drill_q.push_back(row(OP_REMOVE,  32'h0,        0, zero));
      drill_q.push_back(row(OP_REMOVE,  32'h0,        0, zero));
      drill_q.push_back(row(OP_START,   32'h0,        0, zero));
      drill_q.push_back(row(OP_REMOVE,  32'h0,        0, zero));
      drill_q.push_back(row(OP_QUERY,   32'hDEADBEEF, 0, zero));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (drill_q[i]) begin
         d = drill_q[i];
         drive_item(d.op, d.val, d.fixed, d.want);
         idle_burst(1'b1);
      end

      mode = GROW;
      for (n = 0; n < RAND_ITEMS; n++) begin
         if (n % 150 == 0 && n != 0) mode = phase_type'($urandom_range(0, 2));
         case (mode)
            GROW: begin
               p_ins = 30; p_att = 30; p_rem = 10;
            end
            SHRINK: begin
               p_ins = 8; p_att = 7; p_rem = 50;
            end
            default: begin
               p_ins = 20; p_att = 20; p_rem = 25;
            end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < p_ins) begin
            op = OP_INSERT;
         end else if (roll < p_ins + p_att) begin
            op = OP_ATTACH;
         end else if (roll < p_ins + p_att + p_rem) begin
            op = OP_REMOVE;
         end else begin
            case ($urandom_range(0, 5))
               0: op = OP_START;
               1: op = OP_END;
               2, 3: op = OP_ADVANCE;
               4: op = OP_QUERY;
               default: op = OP_UNUSED;
            endcase
         end
         case ($urandom_range(0, 9))
            0: val = '0;
            1: val = ALL_ONES;
            default: val = $urandom;
         endcase
         drive_item(op, val, 1'b0, zero);
         idle_burst(n < RAND_ITEMS - CALM_ITEMS);
      end

      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (pending_q.size() != 0) begin
         note_failure("missing result", pending_q.pop_front(), '0);
      end

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/css_pkg.sv
hdl/css_cell.sv
hdl/css_ctrl.sv
hdl/cursor_sequence_store_unit.sv
hdl/css_checker.sv
sim/tb_cursor_sequence_store_unit.sv
